// File: hw/rtl/bns_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bns_pkg
// Shared types and constants of the nearest-neighbor bitmap scaler.
// ----------------------------------------------------------------------------
package bns_pkg;

    localparam int ADDR_W      = 7;
    localparam int MEM_DEPTH   = 128;
    localparam int DIM_W       = 7;
    localparam int TIDX_W      = 6;
    localparam int COORD_W     = 16;
    localparam int MASK_W      = 64;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 96;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [DIM_W-1:0]   dim_t;
    typedef logic [TIDX_W-1:0]  tidx_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [MASK_W-1:0]  mask_t;

    localparam dim_t MAX_TARGET = 7'd64;

    // Item kinds carried in s_tuser
    localparam logic OPC_LOAD = 1'b0;
    localparam logic OPC_DRAW = 1'b1;

    typedef struct packed {
        logic done;
        dim_t quotient;
        dim_t remainder;
    } div_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/bns_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bns_div
// Restoring divider, one quotient bit per cycle, for the sampling step.
// ----------------------------------------------------------------------------
module bns_div (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire bns_pkg::dim_t        dividend,
    input  wire bns_pkg::dim_t        divisor,
    output bns_pkg::div_status_t      status
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [2:0]           cnt_reg, cnt_next;
    bns_pkg::dim_t        rem_reg, rem_next;
    bns_pkg::dim_t        quo_reg, quo_next;
    bns_pkg::dim_t        dvd_reg, dvd_next;
    bns_pkg::dim_t        dsr_reg, dsr_next;
    logic [bns_pkg::DIM_W:0] trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, dvd_reg[bns_pkg::DIM_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            rem_next  = '0;
            quo_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits back in DIM_W bits
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = bns_pkg::dim_t'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[bns_pkg::DIM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[bns_pkg::DIM_W-1:0];
                quo_next = {quo_reg[bns_pkg::DIM_W-2:0], 1'b0};
            end
            dvd_next = {dvd_reg[bns_pkg::DIM_W-2:0], 1'b0};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'(bns_pkg::DIM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign status.done      = done_reg;
    assign status.quotient  = quo_reg;
    assign status.remainder = rem_reg;

endmodule
`default_nettype wire

// File: hw/rtl/bitmap_nearest_scaler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_nearest_scaler
// Nearest-neighbor scaling of a square 1 bpp icon held in a 128-byte memory.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Content
// s_       in   s_tvalid/s_tready    one load or draw item, kind in s_tuser
// m_       out  m_tvalid/m_tready    one scaled row per transaction, m_tlast
//
// A load item, or a draw of size zero, completes in its accept cycle. A draw
// of target size T is accepted, waits on the step divider, then per row runs
// one setup state, T pixel reads on the single read port, one flush state and
// one output state that holds until m_tready.
// Reset is synchronous (aresetn low); the icon memory is not cleared.
// s_tready is low during a draw; a stalled row holds m_tdata until taken.
// ----------------------------------------------------------------------------
module bitmap_nearest_scaler #(
    parameter int ICON_SIZE = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // load_address[6:0], load_byte[14:7], origin_x[30:15], origin_y[46:31],
    // target_size[53:47], zero fill [55:54]
    input  wire logic [bns_pkg::IN_TDATA_W-1:0]      s_tdata,
    // opcode[0]
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // row_y[15:0], row_x[31:16], row_mask[95:32]
    output logic [bns_pkg::OUT_TDATA_W-1:0]          m_tdata,
    output logic                                     m_tlast
);

    localparam int ROW_BYTES = (ICON_SIZE + 7) / 8;
    localparam int SRC_W     = $clog2(ICON_SIZE + 1);
    localparam int RAW_W     = $clog2(ICON_SIZE * ROW_BYTES) + 1;
    localparam int SUM_W     = (RAW_W > bns_pkg::ADDR_W) ? RAW_W : bns_pkg::ADDR_W;
    localparam bns_pkg::dim_t ICON_DIM = bns_pkg::dim_t'(ICON_SIZE);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_ROW   = 6'b000100,
        ST_PIX   = 6'b001000,
        ST_FLUSH = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // input fields
    logic                  in_opc;
    bns_pkg::addr_t        in_addr;
    logic [7:0]            in_byte;
    bns_pkg::coord_t       in_ox, in_oy;
    bns_pkg::dim_t         in_size, in_size_clamped;

    assign in_opc  = s_tuser;
    assign in_addr = s_tdata[6:0];
    assign in_byte = s_tdata[14:7];
    assign in_ox   = s_tdata[30:15];
    assign in_oy   = s_tdata[46:31];
    assign in_size = s_tdata[53:47];
    assign in_size_clamped = (in_size > bns_pkg::MAX_TARGET) ? bns_pkg::MAX_TARGET : in_size;

    logic s_fire;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // draw context
    bns_pkg::coord_t       ox_reg, ox_next;
    bns_pkg::coord_t       oy_reg, oy_next;
    bns_pkg::dim_t         tsize_reg, tsize_next;
    bns_pkg::dim_t         q_reg, q_next;
    bns_pkg::dim_t         r_reg, r_next;
    bns_pkg::tidx_t        ty_reg, ty_next;
    logic [SRC_W-1:0]      sy_reg, sy_next;
    bns_pkg::dim_t         accy_reg, accy_next;
    logic [SUM_W-1:0]      rbase_reg, rbase_next;
    bns_pkg::tidx_t        tx_reg, tx_next;
    logic [SRC_W-1:0]      sx_reg, sx_next;
    bns_pkg::dim_t         accx_reg, accx_next;
    bns_pkg::mask_t        mask_reg, mask_next;

    // read pipeline
    logic                  rd_vld_reg, rd_vld_next;
    bns_pkg::tidx_t        rd_tx_reg;
    logic [2:0]            rd_sel_reg;
    logic [7:0]            rdata_reg;

    // divider
    logic                  div_start;
    bns_pkg::div_status_t  div_status;

    bns_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (ICON_DIM),
        .divisor  (in_size_clamped),
        .status   (div_status)
    );

    // icon memory
    logic [7:0]            icon_mem [bns_pkg::MEM_DEPTH];
    logic                  mem_we;
    logic                  mem_re;
    bns_pkg::addr_t        rd_addr;
    logic [SUM_W-1:0]      addr_sum;

    assign mem_we   = s_fire && (in_opc == bns_pkg::OPC_LOAD);
    assign mem_re   = (state_reg == ST_PIX);
    assign addr_sum = rbase_reg + SUM_W'(sx_reg >> 3);
    assign rd_addr  = addr_sum[bns_pkg::ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            icon_mem[in_addr] <= in_byte;
        end
        if (mem_re) begin
            rdata_reg <= icon_mem[rd_addr];
        end
    end

    // step helpers: advance a source coordinate by q + r / T per target step
    bns_pkg::dim_t accx_sum, accy_sum;
    logic          last_tx, last_ty;

    assign accx_sum = accx_reg + r_reg;
    assign accy_sum = accy_reg + r_reg;
    assign last_tx  = ({1'b0, tx_reg} == (tsize_reg - 7'd1));
    assign last_ty  = ({1'b0, ty_reg} == (tsize_reg - 7'd1));

    always_comb begin
        state_next  = state_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        tsize_next  = tsize_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        ty_next     = ty_reg;
        sy_next     = sy_reg;
        accy_next   = accy_reg;
        rbase_next  = rbase_reg;
        tx_next     = tx_reg;
        sx_next     = sx_reg;
        accx_next   = accx_reg;
        mask_next   = mask_reg;
        rd_vld_next = 1'b0;
        div_start   = 1'b0;

        // merge the registered pixel read in the cycle after its address
        if (rd_vld_reg && rdata_reg[3'd7 - rd_sel_reg]) begin
            mask_next[rd_tx_reg] = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (in_opc == bns_pkg::OPC_DRAW) && (in_size_clamped != '0)) begin
                    ox_next    = in_ox;
                    oy_next    = in_oy;
                    tsize_next = in_size_clamped;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    q_next     = div_status.quotient;
                    r_next     = div_status.remainder;
                    ty_next    = '0;
                    sy_next    = '0;
                    accy_next  = '0;
                    state_next = ST_ROW;
                end
            end
            ST_ROW: begin
                rbase_next = SUM_W'(SUM_W'(sy_reg) * SUM_W'(ROW_BYTES));
                tx_next    = '0;
                sx_next    = '0;
                accx_next  = '0;
                mask_next  = '0;
                state_next = ST_PIX;
            end
            ST_PIX: begin
                rd_vld_next = 1'b1;
                tx_next     = tx_reg + 6'd1;
                if (accx_sum >= tsize_reg) begin
                    accx_next = accx_sum - tsize_reg;
                    sx_next   = sx_reg + SRC_W'(q_reg) + SRC_W'(1);
                end else begin
                    accx_next = accx_sum;
                    sx_next   = sx_reg + SRC_W'(q_reg);
                end
                if (last_tx) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (last_ty) begin
                        state_next = ST_IDLE;
                    end else begin
                        ty_next = ty_reg + 6'd1;
                        if (accy_sum >= tsize_reg) begin
                            accy_next = accy_sum - tsize_reg;
                            sy_next   = sy_reg + SRC_W'(q_reg) + SRC_W'(1);
                        end else begin
                            accy_next = accy_sum;
                            sy_next   = sy_reg + SRC_W'(q_reg);
                        end
                        state_next = ST_ROW;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        tsize_reg  <= tsize_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        ty_reg     <= ty_next;
        sy_reg     <= sy_next;
        accy_reg   <= accy_next;
        rbase_reg  <= rbase_next;
        tx_reg     <= tx_next;
        sx_reg     <= sx_next;
        accx_reg   <= accx_next;
        mask_reg   <= mask_next;
        rd_tx_reg  <= tx_reg;
        rd_sel_reg <= sx_reg[2:0];
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast  = last_ty;
    assign m_tdata  = {mask_reg, ox_reg, bns_pkg::coord_t'(oy_reg + {10'b0, ty_reg})};

endmodule
`default_nettype wire

// File: dv/tb_bitmap_nearest_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_nearest_scaler
// Self-checking bench for the nearest-neighbor bitmap scaler. The whole icon
// memory is loaded first, then a directed set of loads and draws at the field
// extremes, then random traffic. A local scaling predictor queues the expected
// rows for every accepted item. The monitor checks each row against the oldest
// queued one. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_bitmap_nearest_scaler;
    import bns_pkg::*;

    localparam int ICON      = 32;
    localparam int ROW_BYTES = (ICON + 7) / 8;

    typedef struct {
        logic       kind;
        addr_t      addr;
        logic [7:0] bval;
        coord_t     ox;
        coord_t     oy;
        dim_t       tsize;
        bit         drain;
    } icon_op_t;

    typedef struct {
        coord_t row_y;
        coord_t row_x;
        mask_t  mask;
        logic   last;
    } scaled_row_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = OPC_LOAD;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    bitmap_nearest_scaler #(.ICON_SIZE(ICON)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    icon_op_t    pend_q[$];
    scaled_row_t rows_q[$];
    logic [7:0]  icon_copy[MEM_DEPTH];
    icon_op_t    cur_op;
    scaled_row_t want_row;
    int          rows_predicted = 0;
    int          rows_received  = 0;
    int          errors         = 0;
    int          gap_left       = 0;
    int          stall_left     = 0;
    int          long_hold      = 0;
    logic        quiet          = 1'b0;
    logic        hold_req       = 1'b0;
    logic        hold_done      = 1'b0;

    function automatic icon_op_t mk_load(addr_t addr, logic [7:0] bval);
        icon_op_t op;
        op.kind  = OPC_LOAD;
        op.addr  = addr;
        op.bval  = bval;
        // draw fields are don't-care on a load; keep them noisy
        op.ox    = coord_t'($urandom);
        op.oy    = coord_t'($urandom);
        op.tsize = dim_t'($urandom);
        op.drain = 1'b0;
        return op;
    endfunction

    function automatic icon_op_t mk_draw(coord_t ox, coord_t oy, dim_t tsize);
        icon_op_t op;
        op.kind  = OPC_DRAW;
        op.addr  = addr_t'($urandom);
        op.bval  = 8'($urandom);
        op.ox    = ox;
        op.oy    = oy;
        op.tsize = tsize;
        op.drain = 1'b0;
        return op;
    endfunction

    // Update the icon copy or queue one scaled row per target row.
    task automatic scale_icon(input icon_op_t op);
        int unsigned t, ty, tx, sy, sx, idx;
        scaled_row_t r;
        if (op.kind == OPC_LOAD) begin
            icon_copy[op.addr] = op.bval;
        end else begin
            t = (op.tsize > MAX_TARGET) ? MAX_TARGET : op.tsize;
            for (ty = 0; ty < t; ty++) begin
                sy = (ty * ICON) / t;
                r.mask = '0;
                for (tx = 0; tx < t; tx++) begin
                    sx  = (tx * ICON) / t;
                    idx = (sy * ROW_BYTES + sx / 8) % MEM_DEPTH;
                    r.mask[tx] = icon_copy[idx][7 - (sx % 8)];
                end
                r.row_y = coord_t'(op.oy + ty);
                r.row_x = op.ox;
                r.last  = (ty + 1 == t);
                rows_q.push_back(r);
                rows_predicted++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Driver: one transaction in flight, random gaps after some accepts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            quiet    <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                scale_icon(cur_op);
                if (!quiet && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 7);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pend_q.size() != 0 &&
                             !(pend_q[0].drain && rows_received != rows_predicted)) begin
                    cur_op = pend_q.pop_front();
                    s_tdata  <= {2'b00, cur_op.tsize, cur_op.oy, cur_op.ox,
                                 cur_op.bval, cur_op.addr};
                    s_tuser  <= cur_op.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            quiet <= (pend_q.size() < 30);
        end
    end

    // Receiver ready: random stall bursts, one long hold-off mid-draw.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold = long_hold - 1;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            long_hold = 400;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: compare each row transaction against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (rows_q.size() == 0) begin
                $display("%0t: unexpected row: expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want_row = rows_q.pop_front();
                check_field("row_y", 64'(want_row.row_y), 64'(m_tdata[15:0]));
                check_field("row_x", 64'(want_row.row_x), 64'(m_tdata[31:16]));
                check_field("row_mask", want_row.mask, m_tdata[95:32]);
                check_field("last_row", 64'(want_row.last), 64'(m_tlast));
            end
            rows_received <= rows_received + 1;
            // stall the output mid-draw so the input backs up behind it
            if (rows_received >= 20 && !m_tlast && !hold_done)
                hold_req <= 1'b1;
        end
    end

    initial begin
        icon_op_t op;
        int       big_draws;
        int       kind_pick;
        coord_t   oy;
        dim_t     tsize;
        big_draws = 0;
        for (int i = 0; i < MEM_DEPTH; i++)
            icon_copy[i] = 8'h00;

        // every icon byte is written before any draw reads it
        for (int i = 0; i < MEM_DEPTH; i++)
            pend_q.push_back(mk_load(addr_t'(i), 8'($urandom)));

        // directed: field extremes, zero and oversized targets, y wrap
        pend_q.push_back(mk_load(7'd0, 8'hFF));
        pend_q.push_back(mk_load(7'd127, 8'h00));
        pend_q.push_back(mk_load(7'd5, 8'hAA));
        pend_q.push_back(mk_load(7'd6, 8'h55));
        pend_q.push_back(mk_draw(16'h8000, 16'h7FFF, 7'd0));
        pend_q.push_back(mk_draw(16'h7FFF, 16'h8000, 7'd1));
        pend_q.push_back(mk_draw(16'h0000, 16'h7FFF, 7'd32));
        pend_q.push_back(mk_draw(16'h1234, 16'hFFF0, 7'd64));
        pend_q.push_back(mk_draw(16'hFFFF, 16'h0000, 7'd65));
        pend_q.push_back(mk_draw(16'h8001, 16'h7FF8, 7'd127));
        pend_q.push_back(mk_draw(16'h0010, 16'h0020, 7'd31));
        pend_q.push_back(mk_draw(16'hFF00, 16'h00FF, 7'd33));
        pend_q.push_back(mk_draw(16'h0001, 16'hFFFF, 7'd2));
        pend_q.push_back(mk_draw(16'h4000, 16'hC000, 7'd3));
        pend_q.push_back(mk_load(7'd0, 8'h00));
        pend_q.push_back(mk_load(7'd127, 8'hFF));
        op = mk_draw(16'h0100, 16'h0200, 7'd7);
        op.drain = 1'b1;
        pend_q.push_back(op);
        pend_q.push_back(mk_draw(16'h0300, 16'h0400, 7'd8));
        pend_q.push_back(mk_draw(16'h7FF0, 16'h7FFE, 7'd16));

        // random traffic: mostly small draws, a handful of large ones
        for (int i = 0; i < 4; i++) begin
            kind_pick = $urandom_range(0, 99);
            if (kind_pick < 45) begin
                op = mk_load(addr_t'($urandom), 8'($urandom));
            end else begin
                if (kind_pick < 52 && big_draws < 8) begin
                    tsize = dim_t'($urandom_range(33, 127));
                    big_draws++;
                end else if (kind_pick < 58) begin
                    tsize = 7'd0;
                end else begin
                    tsize = dim_t'($urandom_range(1, 16));
                end
                // bias some draws to just below 16'h8000 so their rows cross into the upper half of y
                oy = ($urandom_range(0, 3) == 0) ? coord_t'(16'h7FF0 + $urandom_range(0, 15))
                                                 : coord_t'($urandom);
                op = mk_draw(coord_t'($urandom), oy, tsize);
            end
            op.drain = ($urandom_range(0, 9) == 0);
            pend_q.push_back(op);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // sample between edges so the driver's updates have settled
        while (pend_q.size() != 0 || s_tvalid || rows_received != rows_predicted)
            @(negedge aclk);
        repeat (200) @(posedge aclk);
        if (rows_q.size() != 0) begin
            $display("%0t: %0d expected rows never arrived", $time, rows_q.size());
            errors++;
        end
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("%0t: timeout", $time);
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/bns_pkg.sv
hw/rtl/bns_div.sv
hw/rtl/bitmap_nearest_scaler.sv
dv/tb_bitmap_nearest_scaler.sv
